// ===== sv/vpn_pkg.sv =====
// Shared types, codes and saturating arithmetic for the vector path normalizer.
package vpn_pkg;

  localparam int CoordW = 32;

  // Input command codes.
  localparam logic [3:0] CMD_MOVE         = 4'd0;
  localparam logic [3:0] CMD_LINE         = 4'd1;
  localparam logic [3:0] CMD_HORIZ        = 4'd2;
  localparam logic [3:0] CMD_VERT         = 4'd3;
  localparam logic [3:0] CMD_CUBIC        = 4'd4;
  localparam logic [3:0] CMD_SMOOTH_CUBIC = 4'd5;
  localparam logic [3:0] CMD_QUAD         = 4'd6;
  localparam logic [3:0] CMD_SMOOTH_QUAD  = 4'd7;
  localparam logic [3:0] CMD_ARC          = 4'd8;
  localparam logic [3:0] CMD_CLOSE        = 4'd9;

  // Output segment kinds.
  localparam logic [2:0] KIND_MOVE  = 3'd0;
  localparam logic [2:0] KIND_LINE  = 3'd1;
  localparam logic [2:0] KIND_CUBIC = 3'd2;
  localparam logic [2:0] KIND_QUAD  = 3'd3;
  localparam logic [2:0] KIND_CLOSE = 3'd4;

  // Kind of the previous segment, used by the smooth forms.
  localparam logic [1:0] CURVE_NONE  = 2'd0;
  localparam logic [1:0] CURVE_CUBIC = 2'd1;
  localparam logic [1:0] CURVE_QUAD  = 2'd2;

  typedef logic signed [CoordW-1:0] coord_t;

  typedef struct packed {
    logic [3:0] command;
    logic       relative;
    logic       start_of_path;
    coord_t     arg_a;
    coord_t     arg_b;
    coord_t     arg_c;
    coord_t     arg_d;
    coord_t     arg_e;
    coord_t     arg_f;
  } seg_t;

  typedef struct packed {
    logic [2:0] segment_kind;
    coord_t     point1_x;
    coord_t     point1_y;
    coord_t     point2_x;
    coord_t     point2_y;
    coord_t     point3_x;
    coord_t     point3_y;
  } res_t;

  // Clamp a value with two guard bits to the signed coordinate range.
  function automatic coord_t sat(input logic signed [CoordW+1:0] v);
    coord_t r;
    if ((v[CoordW+1] == v[CoordW]) && (v[CoordW] == v[CoordW-1])) begin
      r = v[CoordW-1:0];
    end else if (v[CoordW+1]) begin
      r = {1'b1, {(CoordW-1){1'b0}}};
    end else begin
      r = {1'b0, {(CoordW-1){1'b1}}};
    end
    return r;
  endfunction

  // Absolute coordinate: the argument itself, or the saturated offset sum.
  function automatic coord_t coord(input logic rel, input coord_t base, input coord_t arg);
    logic signed [CoordW+1:0] s;
    s = {{2{base[CoordW-1]}}, base} + {{2{arg[CoordW-1]}}, arg};
    return rel ? sat(s) : arg;
  endfunction

  // Mirror of a control point about the current point, saturated.
  function automatic coord_t reflect(input coord_t cur, input coord_t ctl);
    logic signed [CoordW+1:0] s;
    s = {cur[CoordW-1], cur, 1'b0} - {{2{ctl[CoordW-1]}}, ctl};
    return sat(s);
  endfunction

endpackage

// ===== sv/vector_path_normalizer_top.sv =====
// Vector path normalizer: turns path segments into absolute move/line/cubic/quad/close.
//
// Usage: one path segment is transferred on the segment channel (segment_valid,
// segment_ready, segment) and one absolute segment comes back on the result
// channel (result_valid, result_ready, result). Commands with codes above close
// are consumed and give no result. The block keeps the current point, the last
// control point, the subpath start and the kind of the previous curve.
// A segment is taken into the input register (stage) and processed from there
// into the result register. Throughput: one segment per cycle while the result
// is not stalled; all arithmetic is a saturating add or a reflection done in a
// single pass between the input register and the result register, and the path
// state is updated at the same edge.
// Reset (rst, synchronous) empties both registers and clears the path state.
// When the receiver stalls, the result holds; one more segment waits in the
// input register and then segment_ready drops until the result transfers.
module vector_path_normalizer_top (
  input  logic          clk,
  input  logic          rst,
  input  logic          segment_valid,
  output logic          segment_ready,
  input  vpn_pkg::seg_t segment,
  output logic          result_valid,
  input  logic          result_ready,
  output vpn_pkg::res_t result
);

  logic          stage_valid;
  vpn_pkg::seg_t stage;

  vpn_pkg::coord_t current_x, current_y, control_x, control_y;
  vpn_pkg::coord_t subpath_x, subpath_y;
  logic [1:0]      prev_curve;

  vpn_pkg::coord_t current_x_next, current_y_next, control_x_next, control_y_next;
  vpn_pkg::coord_t subpath_x_next, subpath_y_next;
  logic [1:0]      prev_curve_next;
  vpn_pkg::res_t   result_next;

  vpn_pkg::coord_t cur_x, cur_y, ctl_x, ctl_y, sub_x, sub_y;
  logic [1:0]      prev_eff;
  vpn_pkg::coord_t ex, ey, cx, cy;

  logic out_free, unknown, process, load;

  assign out_free      = !result_valid || result_ready;
  assign unknown       = stage.command > vpn_pkg::CMD_CLOSE;
  assign process       = stage_valid && (unknown || out_free);
  assign load          = process && !unknown;
  assign segment_ready = !stage_valid || process;

  always_comb begin
    // Start of path clears the state before the segment is applied.
    cur_x    = stage.start_of_path ? '0 : current_x;
    cur_y    = stage.start_of_path ? '0 : current_y;
    ctl_x    = stage.start_of_path ? '0 : control_x;
    ctl_y    = stage.start_of_path ? '0 : control_y;
    sub_x    = stage.start_of_path ? '0 : subpath_x;
    sub_y    = stage.start_of_path ? '0 : subpath_y;
    prev_eff = stage.start_of_path ? vpn_pkg::CURVE_NONE : prev_curve;

    ex = '0;
    ey = '0;
    cx = '0;
    cy = '0;

    current_x_next  = cur_x;
    current_y_next  = cur_y;
    control_x_next  = ctl_x;
    control_y_next  = ctl_y;
    subpath_x_next  = sub_x;
    subpath_y_next  = sub_y;
    prev_curve_next = vpn_pkg::CURVE_NONE;
    result_next     = '0;

    unique case (stage.command)
      vpn_pkg::CMD_MOVE, vpn_pkg::CMD_LINE, vpn_pkg::CMD_HORIZ,
      vpn_pkg::CMD_VERT, vpn_pkg::CMD_ARC: begin
        ex = (stage.command == vpn_pkg::CMD_VERT) ? cur_x
           : vpn_pkg::coord(stage.relative, cur_x, stage.arg_a);
        ey = (stage.command == vpn_pkg::CMD_HORIZ) ? cur_y
           : (stage.command == vpn_pkg::CMD_VERT)
             ? vpn_pkg::coord(stage.relative, cur_y, stage.arg_a)
             : vpn_pkg::coord(stage.relative, cur_y, stage.arg_b);
        if (stage.command == vpn_pkg::CMD_MOVE) begin
          result_next.segment_kind = vpn_pkg::KIND_MOVE;
          subpath_x_next = ex;
          subpath_y_next = ey;
        end else begin
          result_next.segment_kind = vpn_pkg::KIND_LINE;
        end
        result_next.point1_x = ex;
        result_next.point1_y = ey;
        current_x_next = ex;
        current_y_next = ey;
      end
      vpn_pkg::CMD_CUBIC: begin
        cx = vpn_pkg::coord(stage.relative, cur_x, stage.arg_c);
        cy = vpn_pkg::coord(stage.relative, cur_y, stage.arg_d);
        ex = vpn_pkg::coord(stage.relative, cur_x, stage.arg_e);
        ey = vpn_pkg::coord(stage.relative, cur_y, stage.arg_f);
        result_next.segment_kind = vpn_pkg::KIND_CUBIC;
        result_next.point1_x = vpn_pkg::coord(stage.relative, cur_x, stage.arg_a);
        result_next.point1_y = vpn_pkg::coord(stage.relative, cur_y, stage.arg_b);
        result_next.point2_x = cx;
        result_next.point2_y = cy;
        result_next.point3_x = ex;
        result_next.point3_y = ey;
        control_x_next  = cx;
        control_y_next  = cy;
        current_x_next  = ex;
        current_y_next  = ey;
        prev_curve_next = vpn_pkg::CURVE_CUBIC;
      end
      vpn_pkg::CMD_SMOOTH_CUBIC: begin
        cx = vpn_pkg::coord(stage.relative, cur_x, stage.arg_a);
        cy = vpn_pkg::coord(stage.relative, cur_y, stage.arg_b);
        ex = vpn_pkg::coord(stage.relative, cur_x, stage.arg_c);
        ey = vpn_pkg::coord(stage.relative, cur_y, stage.arg_d);
        result_next.segment_kind = vpn_pkg::KIND_CUBIC;
        // Without a preceding cubic the first control point is the current point.
        result_next.point1_x = (prev_eff == vpn_pkg::CURVE_CUBIC)
                             ? vpn_pkg::reflect(cur_x, ctl_x) : cur_x;
        result_next.point1_y = (prev_eff == vpn_pkg::CURVE_CUBIC)
                             ? vpn_pkg::reflect(cur_y, ctl_y) : cur_y;
        result_next.point2_x = cx;
        result_next.point2_y = cy;
        result_next.point3_x = ex;
        result_next.point3_y = ey;
        control_x_next  = cx;
        control_y_next  = cy;
        current_x_next  = ex;
        current_y_next  = ey;
        prev_curve_next = vpn_pkg::CURVE_CUBIC;
      end
      vpn_pkg::CMD_QUAD, vpn_pkg::CMD_SMOOTH_QUAD: begin
        if (stage.command == vpn_pkg::CMD_QUAD) begin
          cx = vpn_pkg::coord(stage.relative, cur_x, stage.arg_a);
          cy = vpn_pkg::coord(stage.relative, cur_y, stage.arg_b);
          ex = vpn_pkg::coord(stage.relative, cur_x, stage.arg_c);
          ey = vpn_pkg::coord(stage.relative, cur_y, stage.arg_d);
        end else begin
          cx = (prev_eff == vpn_pkg::CURVE_QUAD) ? vpn_pkg::reflect(cur_x, ctl_x) : cur_x;
          cy = (prev_eff == vpn_pkg::CURVE_QUAD) ? vpn_pkg::reflect(cur_y, ctl_y) : cur_y;
          ex = vpn_pkg::coord(stage.relative, cur_x, stage.arg_a);
          ey = vpn_pkg::coord(stage.relative, cur_y, stage.arg_b);
        end
        result_next.segment_kind = vpn_pkg::KIND_QUAD;
        result_next.point1_x = cx;
        result_next.point1_y = cy;
        result_next.point2_x = ex;
        result_next.point2_y = ey;
        control_x_next  = cx;
        control_y_next  = cy;
        current_x_next  = ex;
        current_y_next  = ey;
        prev_curve_next = vpn_pkg::CURVE_QUAD;
      end
      vpn_pkg::CMD_CLOSE: begin
        result_next.segment_kind = vpn_pkg::KIND_CLOSE;
        result_next.point1_x = sub_x;
        result_next.point1_y = sub_y;
        current_x_next = sub_x;
        current_y_next = sub_y;
      end
      default: begin
        // Unknown commands are dropped; the state write is gated off below.
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid  <= 1'b0;
      result_valid <= 1'b0;
      current_x    <= '0;
      current_y    <= '0;
      control_x    <= '0;
      control_y    <= '0;
      subpath_x    <= '0;
      subpath_y    <= '0;
      prev_curve   <= vpn_pkg::CURVE_NONE;
    end else begin
      if (segment_ready) begin
        stage_valid <= segment_valid;
      end
      if (load) begin
        result_valid <= 1'b1;
        current_x    <= current_x_next;
        current_y    <= current_y_next;
        control_x    <= control_x_next;
        control_y    <= control_y_next;
        subpath_x    <= subpath_x_next;
        subpath_y    <= subpath_y_next;
        prev_curve   <= prev_curve_next;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (segment_ready && segment_valid) begin
      stage <= segment;
    end
    if (load) begin
      result <= result_next;
    end
  end

  // The input side only stalls behind a held result.
  assert property (@(posedge clk) disable iff (rst)
    !segment_ready |-> (result_valid && !result_ready))
    else $error("segment_ready low without a stalled result");

  // A processed known command always shows a result next cycle.
  assert property (@(posedge clk) disable iff (rst)
    load |=> result_valid)
    else $error("processed segment produced no result");

  // Unknown commands leave the path state untouched.
  assert property (@(posedge clk) disable iff (rst)
    (stage_valid && unknown) |=>
      ($stable(current_x) && $stable(current_y) && $stable(prev_curve)))
    else $error("unknown command changed the path state");

  // Close returns the current point to the subpath start and reports it.
  assert property (@(posedge clk) disable iff (rst)
    (load && stage.command == vpn_pkg::CMD_CLOSE) |=>
      (current_x == subpath_x && current_y == subpath_y &&
       result.point1_x == subpath_x && result.point1_y == subpath_y))
    else $error("close did not return to the subpath start");

endmodule
